@@ rtl/polyline_length_range_filter_core_defines.svh @@
// Assertion helpers shared by the filter modules.
// Each expects clk and rst_n in scope.
`ifndef POLYLINE_LENGTH_RANGE_FILTER_CORE_DEFINES_SVH
`define POLYLINE_LENGTH_RANGE_FILTER_CORE_DEFINES_SVH

`define PLRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

`define PLRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ rtl/plrf_pkg.sv @@
package plrf_pkg;

  localparam int CFG_INDEX_WIDTH = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LENGTH = CFG_INDEX_WIDTH'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_ACCUM,
    ST_EMIT
  } plrf_state_t;

  typedef struct packed {
    logic load;       // take the input point
    logic sq_step;    // one square / accumulate step
    logic root_step;  // one result bit of the square root
    logic accum;      // add segment length to the polyline sum
    logic emit;       // load the result register
  } plrf_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic sq_done;
    logic root_done;
    logic out_busy;
  } plrf_status_t;

endpackage

@@ rtl/plrf_ctrl.sv @@
`include "polyline_length_range_filter_core_defines.svh"

module plrf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tlast,
  output logic                  in_tready,
  input  plrf_pkg::plrf_status_t status,
  output plrf_pkg::plrf_cmd_t    cmd
);
  import plrf_pkg::*;

  plrf_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (status.have_prev) state_nxt = ST_SQUARE;
          else if (in_tlast)    state_nxt = ST_EMIT;
          else                  state_nxt = ST_IDLE;
        end
      end
      ST_SQUARE: if (status.sq_done) state_nxt = ST_ROOT;
      ST_ROOT:   if (status.root_done) state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = status.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SQUARE: cmd.sq_step   = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_ACCUM:  cmd.accum     = 1'b1;
      ST_EMIT:   cmd.emit      = !status.out_busy;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `PLRF_ASSERT_IMP(a_accum_after_root, state_r == ST_ACCUM, $past(state_r) == ST_ROOT)
  `PLRF_ASSERT_NXT(a_root_exit, (state_r == ST_ROOT) && status.root_done, state_r == ST_ACCUM)

endmodule

@@ rtl/plrf_datapath.sv @@
`include "polyline_length_range_filter_core_defines.svh"

module plrf_datapath #(
  parameter int COORD_WIDTH  = 24,
  parameter int LENGTH_WIDTH = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [COORD_WIDTH-1:0]        point_x,
  input  logic signed [COORD_WIDTH-1:0]        point_y,
  input  logic signed [COORD_WIDTH-1:0]        point_z,
  input  logic                                 last_point,
  input  logic                                 cfg_valid,
  input  logic [plrf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [LENGTH_WIDTH-1:0]              cfg_data,
  input  plrf_pkg::plrf_cmd_t                  cmd,
  output plrf_pkg::plrf_status_t               status,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [LENGTH_WIDTH-1:0]              polyline_length,
  output logic                                 rejected,
  output logic [LENGTH_WIDTH-1:0]              longest_length
);
  import plrf_pkg::*;

  localparam int RW  = COORD_WIDTH + 1;       // root width
  localparam int SW  = 2 * RW;                // sum of squares width
  localparam int RCW = $clog2(RW);
  localparam int AW  = ((LENGTH_WIDTH > RW) ? LENGTH_WIDTH : RW) + 1;
  localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = {LENGTH_WIDTH{1'b1}};
  localparam logic [RCW-1:0]          ROOT_LAST  = RCW'(RW - 1);

  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                          have_prev_r, last_r;
  logic [COORD_WIDTH-1:0]        mag_r [3];
  logic [1:0]                    sq_cnt_r;
  logic [2*COORD_WIDTH-1:0]      prod_r;
  logic [SW-1:0]                 sq_acc_r;
  logic [RCW-1:0]                root_cnt_r;
  logic [RW-1:0]                 rem_r, root_r;
  logic [LENGTH_WIDTH-1:0]       len_sum_r, longest_r, min_len_r, max_len_r;
  logic                          out_valid_r;
  logic [LENGTH_WIDTH-1:0]       out_len_r, out_longest_r;
  logic                          out_rej_r;

  logic signed [COORD_WIDTH:0]   diff [3];
  logic [COORD_WIDTH-1:0]        mag_nxt [3];
  logic [COORD_WIDTH-1:0]        mag_sel;
  logic [RW+1:0]                 rem_shift, trial, rem_diff;
  logic                          root_ge;
  logic [AW-1:0]                 acc_sum;
  logic [LENGTH_WIDTH-1:0]       longest_nxt;

  // |d| is at most 2^COORD_WIDTH - 1, so the magnitude fits COORD_WIDTH bits
  always_comb begin
    diff[0] = (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(prev_x_r);
    diff[1] = (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(prev_y_r);
    diff[2] = (COORD_WIDTH+1)'(point_z) - (COORD_WIDTH+1)'(prev_z_r);
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = diff[i][COORD_WIDTH] ? COORD_WIDTH'(-diff[i]) : COORD_WIDTH'(diff[i]);
    end
  end

  always_comb begin
    unique case (sq_cnt_r)
      2'd0:    mag_sel = mag_r[0];
      2'd1:    mag_sel = mag_r[1];
      2'd2:    mag_sel = mag_r[2];
      default: mag_sel = '0;
    endcase
  end

  // digit-by-digit root, two radicand bits per step
  assign rem_shift = {rem_r, sq_acc_r[SW-1:SW-2]};
  assign trial     = {root_r, 2'b01};
  assign root_ge   = rem_shift >= trial;
  assign rem_diff  = rem_shift - trial;

  assign acc_sum     = AW'(len_sum_r) + AW'(root_r);
  assign longest_nxt = (len_sum_r > longest_r) ? len_sum_r : longest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
      len_sum_r   <= '0;
      longest_r   <= '0;
      min_len_r   <= '0;
      max_len_r   <= LENGTH_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MIN_LENGTH) min_len_r <= cfg_data;
        if (cfg_index == REG_MAX_LENGTH) max_len_r <= cfg_data;
      end
      if (cmd.load) begin
        prev_x_r    <= point_x;
        prev_y_r    <= point_y;
        prev_z_r    <= point_z;
        have_prev_r <= !last_point;
      end
      if (cmd.accum) begin
        len_sum_r <= (acc_sum > AW'(LENGTH_MAX)) ? LENGTH_MAX : acc_sum[LENGTH_WIDTH-1:0];
      end
      if (cmd.emit) begin
        len_sum_r   <= '0;
        longest_r   <= longest_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_r     <= last_point;
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_nxt[i];
      sq_cnt_r   <= '0;
      prod_r     <= '0;
      sq_acc_r   <= '0;
      root_cnt_r <= '0;
      rem_r      <= '0;
      root_r     <= '0;
    end
    if (cmd.sq_step) begin
      prod_r   <= mag_sel * mag_sel;
      sq_acc_r <= sq_acc_r + SW'(prod_r);
      sq_cnt_r <= sq_cnt_r + 2'd1;
    end
    if (cmd.root_step) begin
      sq_acc_r   <= {sq_acc_r[SW-3:0], 2'b00};
      rem_r      <= root_ge ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
      root_r     <= {root_r[RW-2:0], root_ge};
      root_cnt_r <= root_cnt_r + RCW'(1);
    end
    if (cmd.emit) begin
      out_len_r     <= len_sum_r;
      out_rej_r     <= (len_sum_r < min_len_r) || (len_sum_r > max_len_r);
      out_longest_r <= longest_nxt;
    end
  end

  always_comb begin
    status.have_prev = have_prev_r;
    status.last      = last_r;
    status.sq_done   = sq_cnt_r == 2'd3;
    status.root_done = root_cnt_r == ROOT_LAST;
    status.out_busy  = out_valid_r && !out_tready;
  end

  assign out_tvalid      = out_valid_r;
  assign polyline_length = out_len_r;
  assign rejected        = out_rej_r;
  assign longest_length  = out_longest_r;

  `PLRF_ASSERT_NXT(a_sum_cleared, cmd.emit, len_sum_r == '0)
  `PLRF_ASSERT_IMP(a_longest_covers, out_valid_r, longest_length >= polyline_length)
  `PLRF_ASSERT_NXT(a_longest_mono, 1'b1, longest_r >= $past(longest_r))

endmodule

@@ rtl/polyline_length_range_filter_core.sv @@
// A point that closes a segment passes load, four square/accumulate steps on the shared
// multiplier, COORD_WIDTH+1 root steps and one add; a first point of a polyline is only
// loaded. A last point adds a step that loads the result register, once no earlier result
// still waits for out_tready.
// in_tready is high only in idle, so a new point is taken only after the previous one is through.
// Reset (rst_n low, synchronous) clears point, sum and longest; thresholds go to 0 / all ones.
module polyline_length_range_filter_core #(
  parameter int COORD_WIDTH  = 24,
  parameter int LENGTH_WIDTH = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // point_x, point_y, point_z, zero pad to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // polyline_length, longest_length, zero pad to bytes
  output logic [((2*LENGTH_WIDTH+7)/8)*8-1:0]  out_tdata,
  // rejected
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plrf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [LENGTH_WIDTH-1:0]              cfg_data
);
  import plrf_pkg::*;

  localparam int OUT_DW = ((2*LENGTH_WIDTH+7)/8)*8;

  plrf_cmd_t               cmd;
  plrf_status_t            status;
  logic [LENGTH_WIDTH-1:0] polyline_length, longest_length;

  assign cfg_ready = 1'b1;

  plrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  plrf_datapath #(
    .COORD_WIDTH  (COORD_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .point_x         (in_tdata[COORD_WIDTH-1:0]),
    .point_y         (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .point_z         (in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .last_point      (in_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .polyline_length (polyline_length),
    .rejected        (out_tuser),
    .longest_length  (longest_length)
  );

  assign out_tdata = OUT_DW'({longest_length, polyline_length});

endmodule
